// File: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the stream find/replace block
// widths, register index codes and the pending buffer command struct
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 64;   // pattern and replacement words
  localparam int LEN_W    = 4;    // stored length registers
  localparam int BIDX_W   = 3;    // byte index into a 64-bit word
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;

  // pending buffer commands, at most one set per cycle
  typedef struct packed {
    logic push;
    logic shift;
    logic clear;
  } pend_cmd_t;

endpackage

// File: src/sfr_prefix.sv
// ----------------------------------------------------------------------------
// sfr_prefix: prefix compare unit
// checks whether the pending bytes are a prefix of the pattern
// ----------------------------------------------------------------------------
module sfr_prefix #(
  parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
  parameter int CW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] entries,
  input  logic [CW-1:0]                               count,
  input  logic [CW-1:0]                               plen,
  input  logic [sfr_pkg::WORD_W-1:0]                  pattern,
  output logic                                        is_prefix
);

  always_comb begin
    is_prefix = (count <= plen);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < count) && (entries[i] != pattern[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W])) begin
        is_prefix = 1'b0;
      end
    end
  end

endmodule

// File: src/sfr_pend.sv
// ----------------------------------------------------------------------------
// sfr_pend: pending byte buffer
// holds bytes that may still start a match; push at the back, shift out the front
// ----------------------------------------------------------------------------
module sfr_pend #(
  parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN,
  parameter int CW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  sfr_pkg::pend_cmd_t                          cmd,
  input  logic [sfr_pkg::BYTE_W-1:0]                  push_byte,
  output logic [CW-1:0]                               count,
  output logic [sfr_pkg::BYTE_W-1:0]                  front,
  output logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] entries
);

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] store_r, store_nxt;
  logic [CW-1:0]                               count_r, count_nxt;

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.push) begin
      store_nxt[count_r[IW-1:0]] = push_byte;
      count_nxt = count_r + CW'(1);
    end else if (cmd.shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        store_nxt[i] = store_r[i+1];
      end
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count   = count_r;
  assign front   = store_r[0];
  assign entries = store_r;

endmodule

// File: src/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: streaming find and replace on a byte stream
// replaces each leftmost non-overlapping occurrence of a pattern of up to
// MAX_PATTERN bytes with a replacement of up to MAX_REPLACEMENT bytes
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in_     | input     | in_valid / in_ready    | in_data_byte, in_end_of_text
//  out_    | output    | out_valid / out_ready  | out_byte, out_byte_present, out_last
//  cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
//  one input transaction causes 0..8 results with the default sizes; the
//    single output register moves at most one result per cycle
//  each scan cycle runs the single prefix compare once and drops at most one byte
//  reset: synchronous, active low; clears sequencer, pending count, config
//  stalls: the sequencer waits in place while the output register is held
//
module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_end_of_text,
  // result stream
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_byte_present,
  output logic                            out_last,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::WORD_W-1:0]      cfg_wdata
);

  localparam int CW  = $clog2(MAX_PATTERN + 1);
  localparam int RCW = $clog2(MAX_REPLACEMENT + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // ready for the next byte
  localparam logic [2:0] S_PASS  = 3'd1;  // empty pattern, forward the byte
  localparam logic [2:0] S_SCAN  = 3'd2;  // drop front bytes until prefix again
  localparam logic [2:0] S_REPL  = 3'd3;  // send replacement bytes
  localparam logic [2:0] S_FLUSH = 3'd4;  // end of text, drain pending bytes
  localparam logic [2:0] S_BARE  = 3'd5;  // end of text with nothing to send

  // config registers
  logic [sfr_pkg::WORD_W-1:0] pattern_bytes_r;
  logic [sfr_pkg::LEN_W-1:0]  pattern_length_r;
  logic [sfr_pkg::WORD_W-1:0] replacement_bytes_r;
  logic [sfr_pkg::LEN_W-1:0]  replacement_length_r;

  // sequencer
  logic [2:0]                 state_r, state_nxt;
  logic [RCW-1:0]             ridx_r, ridx_nxt;
  logic [sfr_pkg::BYTE_W-1:0] byte_r;
  logic                       last_r;

  // output register
  logic                       out_valid_r;
  logic [sfr_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_present_r;
  logic                       out_last_r;

  // pending buffer and compare unit
  sfr_pkg::pend_cmd_t                          pend_cmd;
  logic [CW-1:0]                               pend_count;
  logic [sfr_pkg::BYTE_W-1:0]                  pend_front;
  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] pend_entries;
  logic                                        is_prefix;

  logic [CW-1:0]              plen_eff;
  logic [RCW-1:0]             rlen_eff;
  logic                       in_xact;
  logic                       out_free;
  logic                       emit;
  logic [sfr_pkg::BYTE_W-1:0] emit_byte;
  logic                       emit_present;
  logic                       emit_last;
  logic [sfr_pkg::BYTE_W-1:0] repl_byte;

  // oversized lengths act as the maximum
  assign plen_eff = (pattern_length_r > sfr_pkg::LEN_W'(MAX_PATTERN)) ?
                    CW'(MAX_PATTERN) : CW'(pattern_length_r);
  assign rlen_eff = (replacement_length_r > sfr_pkg::LEN_W'(MAX_REPLACEMENT)) ?
                    RCW'(MAX_REPLACEMENT) : RCW'(replacement_length_r);

  assign in_ready = (state_r == S_IDLE);
  assign in_xact  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign repl_byte = replacement_bytes_r[sfr_pkg::BYTE_W*sfr_pkg::BIDX_W'(ridx_r) +:
                                         sfr_pkg::BYTE_W];

  // config writes; the pattern is frozen while a partial match is pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r      <= '0;
      pattern_length_r     <= '0;
      replacement_bytes_r  <= '0;
      replacement_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::REG_PATTERN_BYTES: begin
          if (pend_count == '0) pattern_bytes_r <= cfg_wdata;
        end
        sfr_pkg::REG_PATTERN_LENGTH: begin
          if (pend_count == '0) pattern_length_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        end
        sfr_pkg::REG_REPLACEMENT_BYTES: begin
          replacement_bytes_r <= cfg_wdata;
        end
        sfr_pkg::REG_REPLACEMENT_LENGTH: begin
          replacement_length_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: one emitted byte or one decision per cycle unless output is held
  always_comb begin
    state_nxt    = state_r;
    ridx_nxt     = ridx_r;
    pend_cmd     = '0;
    emit         = 1'b0;
    emit_byte    = '0;
    emit_present = 1'b1;
    emit_last    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          if (plen_eff == '0) begin
            state_nxt = S_PASS;
          end else begin
            pend_cmd.push = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_PASS: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = byte_r;
          emit_last = last_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if ((pend_count != '0) && !is_prefix) begin
          // front byte can no longer start a match, send it on
          if (out_free) begin
            emit           = 1'b1;
            emit_byte      = pend_front;
            emit_last      = last_r && (pend_count == CW'(1));
            pend_cmd.shift = 1'b1;
          end
        end else if (pend_count == plen_eff) begin
          // whole pattern seen
          pend_cmd.clear = 1'b1;
          ridx_nxt       = '0;
          if (rlen_eff != '0) begin
            state_nxt = S_REPL;
          end else if (last_r) begin
            state_nxt = S_BARE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (last_r && (pend_count != '0)) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = repl_byte;
          emit_last = last_r && (ridx_r == rlen_eff - RCW'(1));
          ridx_nxt  = ridx_r + RCW'(1);
          if (ridx_r == rlen_eff - RCW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_byte      = pend_front;
          emit_last      = (pend_count == CW'(1));
          pend_cmd.shift = 1'b1;
          if (pend_count == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_BARE: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_present = 1'b0;
          emit_last    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ridx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ridx_r  <= ridx_nxt;
    end
  end

  // captured input transaction
  always_ff @(posedge clk) begin
    if (in_xact) begin
      byte_r <= in_data_byte;
      last_r <= in_end_of_text;
    end
  end

  // output register, loaded only when free or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r    <= emit_byte;
      out_present_r <= emit_present;
      out_last_r    <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_last         = out_last_r;

  sfr_pend #(
    .MAX_PATTERN (MAX_PATTERN),
    .CW          (CW)
  ) u_pend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pend_cmd),
    .push_byte (in_data_byte),
    .count     (pend_count),
    .front     (pend_front),
    .entries   (pend_entries)
  );

  sfr_prefix #(
    .MAX_PATTERN (MAX_PATTERN),
    .CW          (CW)
  ) u_prefix (
    .entries   (pend_entries),
    .count     (pend_count),
    .plen      (plen_eff),
    .pattern   (pattern_bytes_r),
    .is_prefix (is_prefix)
  );

`ifndef SYNTHESIS
  // between transactions a partial match is always shorter than the pattern
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((pend_count == '0) || (pend_count < plen_eff)))
    else $error("pending count not below pattern length while idle");

  // a byte with a non-empty pattern always goes to the scan step
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xact && (plen_eff != '0)) |=> (state_r == S_SCAN))
    else $error("accepted byte did not enter scan");

  // the buffer is empty while the replacement is sent
  a_repl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPL) |-> (pend_count == '0))
    else $error("pending bytes left during replacement");

  // a bare result only ever marks the end of the text
  a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_present_r) |-> out_last_r)
    else $error("bare result without end marker");
`endif

endmodule

// File: tb/sv/stream_find_replace_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_find_replace_test: self-checking bench for the stream find/replace
// drives byte texts through the input channel under several configurations,
// predicts every rewritten byte and end marker, and checks them in order
// ----------------------------------------------------------------------------
module stream_find_replace_test;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 12;    // one transaction with no result
  localparam int unsigned LONG_HOLD     = 200;   // receiver hold-off, in cycles
  localparam int unsigned MAX_REPORTS   = 10;

  // index outside the register map, writes to it must change nothing
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

  typedef struct packed {
    logic [sfr_pkg::BYTE_W-1:0] data;
    logic                       eot;
  } src_item_t;

  typedef struct packed {
    logic [sfr_pkg::BYTE_W-1:0] data;
    logic                       present;
    logic                       last;
  } out_item_t;

  // dut inputs, all known from time zero
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [sfr_pkg::BYTE_W-1:0]    in_data_byte = '0;
  logic                          in_end_of_text = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [sfr_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_byte_present;
  logic                          out_last;
  logic                          cfg_we = 1'b0;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sfr_pkg::WORD_W-1:0]    cfg_wdata = '0;

  // stimulus and scoreboard
  src_item_t   source_q[$];       // bytes waiting for the driver
  out_item_t   rewrite_q[$];      // rewritten bytes still to come out
  int unsigned items_queued = 0;
  int unsigned items_issued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          in_taken = 1'b0;   // input transaction at the last rising edge

  // pacing controls, set by the sequence at rising edges
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          tx_pause = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  // predictor state: registers as the block holds them and the match buffer
  logic [sfr_pkg::WORD_W-1:0] pat_word = '0;
  logic [sfr_pkg::LEN_W-1:0]  pat_len_reg = '0;
  logic [sfr_pkg::WORD_W-1:0] rep_word = '0;
  logic [sfr_pkg::LEN_W-1:0]  rep_len_reg = '0;
  logic [sfr_pkg::BYTE_W-1:0] held[8];
  int unsigned                held_cnt = 0;

  stream_find_replace uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // lengths above eight act as eight
  function automatic int unsigned capped_len(logic [sfr_pkg::LEN_W-1:0] v);
    return (v > 4'd8) ? 8 : int'(v);
  endfunction

  // true while the held bytes could still grow into the pattern
  function automatic bit held_is_prefix(int unsigned plen);
    int unsigned k;
    if (held_cnt > plen) return 1'b0;
    for (k = 0; k < held_cnt; k++) begin
      if (held[k] != pat_word[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // pattern registers are frozen while a partial match is held
  function automatic void apply_reg_write(logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                          logic [sfr_pkg::WORD_W-1:0] val);
    case (idx)
      sfr_pkg::REG_PATTERN_BYTES: begin
        if (held_cnt == 0) pat_word = val;
      end
      sfr_pkg::REG_PATTERN_LENGTH: begin
        if (held_cnt == 0) pat_len_reg = val[sfr_pkg::LEN_W-1:0];
      end
      sfr_pkg::REG_REPLACEMENT_BYTES:  rep_word = val;
      sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg = val[sfr_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // one source byte in, its burst of rewritten bytes onto the expected queue
  function automatic void predict_rewrite(logic [sfr_pkg::BYTE_W-1:0] b, logic eot);
    out_item_t   burst[$];
    int unsigned plen;
    int unsigned rlen;
    int unsigned k;
    plen = capped_len(pat_len_reg);
    if (plen == 0) begin
      // empty pattern: straight pass through
      burst.push_back('{b, 1'b1, 1'b0});
    end else begin
      if (held_cnt < 8) begin
        held[held_cnt] = b;
        held_cnt++;
      end
      // release bytes from the front until the rest is a pattern prefix again
      while (held_cnt > 0 && !held_is_prefix(plen)) begin
        burst.push_back('{held[0], 1'b1, 1'b0});
        for (k = 0; k < 7; k++) held[k] = held[k+1];
        held_cnt--;
      end
      if (held_cnt == plen) begin
        rlen = capped_len(rep_len_reg);
        for (k = 0; k < rlen; k++) burst.push_back('{rep_word[8*k +: 8], 1'b1, 1'b0});
        held_cnt = 0;
      end
      if (eot) begin
        for (k = 0; k < held_cnt; k++) burst.push_back('{held[k], 1'b1, 1'b0});
        held_cnt = 0;
      end
    end
    if (eot) begin
      // nothing left to carry the end flag: bare end marker
      if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0});
      burst[burst.size()-1].last = 1'b1;
    end
    while (burst.size() != 0) rewrite_q.push_back(burst.pop_front());
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one source byte per transaction, changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    src_item_t nxt;
    if (!in_valid || in_taken) begin
      if (rst_n && !tx_pause && source_q.size() != 0 &&
          $urandom_range(99) >= tx_idle_pct) begin
        nxt = source_q.pop_front();
        in_valid       <= 1'b1;
        in_data_byte   <= nxt.data;
        in_end_of_text <= nxt.eot;
        items_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results against the oldest expectation, then feeds the
  // predictor with the input transaction of the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rewrite_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte %02h present %0d last %0d",
                   out_byte, out_byte_present, out_last);
      end else begin
        want = rewrite_q.pop_front();
        if (out_byte !== want.data || out_byte_present !== want.present ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected byte %02h present %0d last %0d, got %02h %0d %0d",
                     want.data, want.present, want.last,
                     out_byte, out_byte_present, out_last);
        end
      end
    end
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      predict_rewrite(in_data_byte, in_end_of_text);
      items_accepted++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL stream_find_replace");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------------

  // register write, only issued while the block is idle
  task automatic write_reg(logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [sfr_pkg::WORD_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    apply_reg_write(idx, val);
  endtask

  // length value with junk in the bits above the stored nibble
  function automatic logic [sfr_pkg::WORD_W-1:0] len_word(int unsigned n);
    logic [sfr_pkg::WORD_W-1:0] w;
    w = {$urandom(), $urandom()};
    w[sfr_pkg::LEN_W-1:0] = n[sfr_pkg::LEN_W-1:0];
    return w;
  endfunction

  task automatic queue_byte(logic [sfr_pkg::BYTE_W-1:0] b, logic eot);
    @(posedge clk);
    source_q.push_back('{b, eot});
    items_queued++;
  endtask

  task automatic set_pace(int unsigned tx, int unsigned rx);
    @(posedge clk);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // all bytes taken, every result seen, then room for a last silent transaction
  task automatic wait_idle();
    do @(negedge clk); while (items_accepted != items_queued || rewrite_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // texts built mostly from pattern copies and prefixes, with some noise
  task automatic queue_texts(int unsigned min_items);
    src_item_t   text[$];
    int unsigned got;
    int unsigned segs;
    int unsigned s;
    int unsigned k;
    int unsigned plen;
    int unsigned cut;
    plen = capped_len(pat_len_reg);
    got = 0;
    @(posedge clk);
    while (got < min_items) begin
      text.delete();
      segs = $urandom_range(1, 5);
      for (s = 0; s < segs; s++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // whole pattern
            for (k = 0; k < plen; k++) text.push_back('{pat_word[8*k +: 8], 1'b0});
          end
          4, 5: begin
            // broken-off start of the pattern
            if (plen > 1) begin
              cut = $urandom_range(1, plen - 1);
              for (k = 0; k < cut; k++) text.push_back('{pat_word[8*k +: 8], 1'b0});
            end
          end
          6, 7: begin
            // pattern bytes picked at random
            repeat ($urandom_range(1, 4)) begin
              if (plen == 0) text.push_back('{8'($urandom_range(255)), 1'b0});
              else text.push_back('{pat_word[8*$urandom_range(0, plen - 1) +: 8], 1'b0});
            end
          end
          default: begin
            repeat ($urandom_range(1, 3)) text.push_back('{8'($urandom_range(255)), 1'b0});
          end
        endcase
      end
      if (text.size() == 0) text.push_back('{8'($urandom_range(255)), 1'b0});
      text[text.size()-1].eot = 1'b1;
      got += text.size();
      items_queued += text.size();
      while (text.size() != 0) source_q.push_back(text.pop_front());
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    logic [sfr_pkg::WORD_W-1:0] pw;
    int unsigned                ph;
    int unsigned                k;
    int unsigned                plen;
    int unsigned                rlen;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset configuration has an empty pattern, bytes pass through
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // "AB" -> "XYZ", plus a write to an unmapped index that must be ignored
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h4241);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, len_word(2));
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, len_word(3));
    write_reg(REG_UNMAPPED, '1);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h42, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h42, 1'b0);
    queue_byte(8'h41, 1'b1);    // partial match flushed by end of text
    wait_idle();

    // pattern rewrite while a partial match is held is dropped
    queue_byte(8'h41, 1'b0);
    wait_idle();
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'hFF00);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, len_word(1));
    queue_byte(8'h42, 1'b1);
    wait_idle();

    // deleted match on the last byte leaves a bare end marker
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, len_word(0));
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h42, 1'b1);
    wait_idle();

    // oversized lengths act as eight, full-width pattern and replacement
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0011_2233_4455_66FF);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, '1);
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, len_word(12));
    for (k = 0; k < 8; k++) queue_byte(pat_word[8*k +: 8], k == 7);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h66, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h00, 1'b1);    // breaks the match and ends the text
    wait_idle();

    // random phases, rotating through the pacing profiles
    for (ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0:       set_pace(0, 0);
        1:       set_pace(69, 0);
        2:       set_pace(0, 69);
        default: set_pace(12, 12);
      endcase
      case (ph)
        0: begin plen = 1; rlen = 0; end
        1: begin plen = 8; rlen = 8; end
        2: begin plen = 0; rlen = $urandom_range(0, 8); end
        3: begin plen = $urandom_range(9, 15); rlen = 15; end
        default: begin plen = $urandom_range(1, 8); rlen = $urandom_range(0, 15); end
      endcase
      // small alphabet so matches and near-matches are frequent
      for (k = 0; k < 8; k++)
        pw[8*k +: 8] = ($urandom_range(3) != 0) ? 8'(8'h61 + $urandom_range(2))
                                                : 8'($urandom_range(255));
      write_reg(sfr_pkg::REG_PATTERN_BYTES, pw);
      write_reg(sfr_pkg::REG_PATTERN_LENGTH, len_word(plen));
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom(), $urandom()});
      write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, len_word(rlen));
      queue_texts(28);
      if (ph == 5) begin
        // sender stops until every outstanding result is out
        do @(posedge clk); while (source_q.size() > 15);
        tx_pause = 1'b1;
        do @(negedge clk); while (items_issued != items_accepted || rewrite_q.size() != 0);
        @(posedge clk);
        tx_pause = 1'b0;
      end
      wait_idle();
    end

    // back pressure: long receiver hold-off while the sender keeps offering
    set_pace(0, 0);
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h6362_6261);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, len_word(3));
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom(), $urandom()});
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, len_word(8));
    queue_texts(34);
    @(posedge clk);
    hold_requests++;
    wait_idle();

    if (mismatches == 0 && rewrite_q.size() == 0) begin
      $display("PASS stream_find_replace");
    end else begin
      $display("FAIL stream_find_replace");
    end
    $finish;
  end

endmodule
